### rtl/nsh_pkg.sv
// ----------------------------------------------------------------------------
// nsh_pkg
// Types, round constants and round functions for the two-stage SHA-256 hash.
// ----------------------------------------------------------------------------
`default_nettype none

package nsh_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned NumState = 8;
  localparam int unsigned NumBlk   = 16;
  localparam int unsigned NumRound = 64;
  localparam int unsigned NumMid   = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // Request codes
  localparam logic ReqLoad = 1'b0;
  localparam logic ReqHash = 1'b1;

  // Block word that the nonce replaces
  localparam logic [3:0] NonceSlot = 4'd3;

  // Padding of the second block
  localparam logic [WordW-1:0] PadWord  = 32'h8000_0000;
  localparam logic [WordW-1:0] LenWord  = 32'h0000_0300;
  localparam logic [3:0]       PadSlot  = 4'd8;
  localparam logic [3:0]       LenSlot  = 4'd15;

  localparam logic [WordW-1:0] RoundK [NumRound] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Fixed initial value of the second compression
  localparam logic [WordW-1:0] FixedIv [NumState] = '{
    32'hdfa9bf2c, 32'hb72074d4, 32'h6bb01122, 32'hd338e869,
    32'haa3ff126, 32'h475bbf30, 32'h8fd52e5b, 32'h9f75c9ad
  };

  typedef struct packed {
    logic             req_type;
    logic [3:0]       word_index;
    logic [WordW-1:0] word_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]       digest_index;
    logic [WordW-1:0] digest_word;
    logic             last_word;
  } out_word_t;

  function automatic logic [WordW-1:0] big_sigma0(input logic [WordW-1:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [WordW-1:0] big_sigma1(input logic [WordW-1:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [WordW-1:0] small_sigma0(input logic [WordW-1:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [WordW-1:0] small_sigma1(input logic [WordW-1:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic logic [WordW-1:0] choose(input logic [WordW-1:0] e,
                                              input logic [WordW-1:0] f,
                                              input logic [WordW-1:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [WordW-1:0] majority(input logic [WordW-1:0] a,
                                                input logic [WordW-1:0] b,
                                                input logic [WordW-1:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

`default_nettype wire

### rtl/nonce_sha256_two_stage_hash_top.sv
// ----------------------------------------------------------------------------
// nonce_sha256_two_stage_hash_top
// Two chained SHA-256 compressions on one round unit, midstate from config.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): a load word
//   (req_type 0) writes word_value into block slot word_index; the block
//   stays idle. A hash word (req_type 1) uses word_value as nonce for slot 3.
//   Output channel (out_valid_o / out_stall_i / out_data_o): a hash word
//   yields eight digest words, index 0 first, last_word set on index 7.
//   Config channel (cfg_valid_i / cfg_ready_o): index 0..3 writes a 64-bit
//   midstate pair; higher indexes are dropped. Write only while idle.
// Timing: one round per cycle on a single round unit. A hash word runs
//   accept, 64 rounds, the midstate fold and 64 rounds, then emits the
//   eight digest words; each receiver stall holds the emit phase. While
//   the last digest word waits, the block already accepts the next word.
// Reset: control state and midstate registers clear; the block store holds
//   no reset value and every slot must be loaded before the first hash.
// ----------------------------------------------------------------------------
`default_nettype none

module nonce_sha256_two_stage_hash_top
  import nsh_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_word_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_word_t                out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS1,
    S_FOLD,
    S_PASS2,
    S_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic [5:0]        rnd_q, rnd_d;
  logic [2:0]        emit_q, emit_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_data_q;

  logic [CfgDataW-1:0] mid_q [NumMid];
  logic [WordW-1:0]    store_mem [NumBlk];
  logic [WordW-1:0]    rdata_q;
  logic [WordW-1:0]    nonce_q;
  logic [WordW-1:0]    v_q [NumState];
  logic [WordW-1:0]    sched_q [NumBlk];
  logic [WordW-1:0]    h1_q [NumState];

  logic              in_acc;
  logic              load_acc;
  logic              hash_acc;
  logic              out_acc;
  logic              out_load;
  logic              rounds_on;
  logic [3:0]        rd_addr;
  logic [WordW-1:0]  msg_w;
  logic [WordW-1:0]  sched_w;
  logic [WordW-1:0]  round_w;
  logic [WordW-1:0]  t1;
  logic [WordW-1:0]  t2;
  logic [WordW-1:0]  mid_word [NumState];

  // Handshakes
  assign in_acc      = in_valid_i && !in_stall_o;
  assign load_acc    = in_acc && (in_data_i.req_type == ReqLoad);
  assign hash_acc    = in_acc && (in_data_i.req_type == ReqHash);
  assign out_acc     = out_valid_q && !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign rounds_on   = (state_q == S_PASS1) || (state_q == S_PASS2);
  assign out_load    = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  // Midstate words: even word in the high half of each register
  always_comb begin
    for (int i = 0; i < NumState; i++) begin
      mid_word[i] = (i % 2 == 0) ? mid_q[i/2][63:32] : mid_q[i/2][31:0];
    end
  end

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumMid; i++) begin
        mid_q[i] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i < CfgIdxW'(NumMid))) begin
      mid_q[cfg_index_i[1:0]] <= cfg_data_i;
    end
  end

  // Block store: write on load, prefetch the next round's slot
  assign rd_addr = (state_q == S_IDLE) ? 4'd0 : rnd_q[3:0] + 4'd1;

  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      store_mem[in_data_i.word_index] <= in_data_i.word_value;
    end
    rdata_q <= store_mem[rd_addr];
  end

  // Message word for the first sixteen rounds of each pass
  always_comb begin
    if (state_q == S_PASS1) begin
      msg_w = (rnd_q[3:0] == NonceSlot) ? nonce_q : rdata_q;
    end else if (!rnd_q[3]) begin
      msg_w = h1_q[rnd_q[2:0]];
    end else if (rnd_q[3:0] == PadSlot) begin
      msg_w = PadWord;
    end else if (rnd_q[3:0] == LenSlot) begin
      msg_w = LenWord;
    end else begin
      msg_w = '0;
    end
  end

  // Schedule expansion from the sixteen-word window
  assign sched_w = sched_q[0] + small_sigma0(sched_q[1]) + sched_q[9]
                 + small_sigma1(sched_q[14]);
  assign round_w = (rnd_q[5:4] == 2'd0) ? msg_w : sched_w;

  // Shared round unit
  assign t1 = v_q[7] + big_sigma1(v_q[4]) + choose(v_q[4], v_q[5], v_q[6])
            + RoundK[rnd_q] + round_w;
  assign t2 = big_sigma0(v_q[0]) + majority(v_q[0], v_q[1], v_q[2]);

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (hash_acc) begin
      nonce_q <= in_data_i.word_value;
      for (int i = 0; i < NumState; i++) begin
        v_q[i] <= mid_word[i];
      end
    end else if (rounds_on) begin
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
      for (int i = 0; i < NumBlk - 1; i++) begin
        sched_q[i] <= sched_q[i+1];
      end
      sched_q[NumBlk-1] <= round_w;
    end else if (state_q == S_FOLD) begin
      for (int i = 0; i < NumState; i++) begin
        h1_q[i] <= v_q[i] + mid_word[i];
        v_q[i]  <= FixedIv[i];
      end
    end
    if (out_load) begin
      out_data_q.digest_index <= emit_q;
      out_data_q.digest_word  <= v_q[emit_q] + FixedIv[emit_q];
      out_data_q.last_word    <= (emit_q == 3'(NumState - 1));
    end
  end

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    emit_d      = emit_q;
    out_valid_d = out_valid_q;
    if (out_acc) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (hash_acc) begin
          state_d = S_PASS1;
          rnd_d   = '0;
        end
      end
      S_PASS1: begin
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'(NumRound - 1)) begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        state_d = S_PASS2;
        rnd_d   = '0;
      end
      S_PASS2: begin
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'(NumRound - 1)) begin
          state_d = S_EMIT;
          emit_d  = '0;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          emit_d      = emit_q + 3'd1;
          if (emit_q == 3'(NumState - 1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rnd_q       <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  // A hash word starts the first pass at round zero
  a_hash_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_acc |=> (state_q == S_PASS1) && (rnd_q == 6'd0))
    else $error("hash word did not start the first pass");

  // Rounds advance by one each cycle within a pass
  a_round_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_PASS1) || (state_q == S_PASS2)) && (rnd_q != 6'd63)
    |=> (state_q == $past(state_q)) && (rnd_q == $past(rnd_q) + 6'd1))
    else $error("round counter skipped");

  // New output words come only from the emit phase
  a_emit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_EMIT))
    else $error("output word raised outside emit");

  // Load words leave the block idle
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_acc |=> !in_stall_o)
    else $error("load word left the block busy");
`endif

endmodule

`default_nettype wire

### sim/tb_nonce_sha256_two_stage_hash_top.sv
// ----------------------------------------------------------------------------
// tb_nonce_sha256_two_stage_hash_top
// Self-checking bench for the two-stage midstate SHA-256 hash block. Stimulus
// loads block words and issues nonce hashes. Each accepted hash is run through
// a local double-compression model, and every digest word that leaves the block
// is compared field by field with it. Both channels idle and stall at random,
// and the midstate registers are rewritten between phases.
// ----------------------------------------------------------------------------

module tb_nonce_sha256_two_stage_hash_top;
  import nsh_pkg::*;

  typedef logic [7:0][31:0]  state_t;
  typedef logic [15:0][31:0] block_t;

  // Midstate register indexes
  localparam logic [CfgIdxW-1:0] RegMid01 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMid23 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMid45 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMid67 = 3'd3;
  localparam int unsigned        NumMidRegs = 4;

  localparam int unsigned NonceWord = 3;
  localparam logic [31:0] BlkPad    = 32'h8000_0000;
  localparam logic [31:0] BlkLen    = 32'h0000_0300;
  localparam int unsigned LongHold  = 800;
  localparam int unsigned DrainWait = 8;
  localparam int unsigned TailWait  = 200;

  localparam logic [31:0] ShaK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Second-stage initial value, word 7 in the top slice
  localparam state_t SecondIv = {
    32'h9f75c9ad, 32'h8fd52e5b, 32'h475bbf30, 32'haa3ff126,
    32'hd338e869, 32'h6bb01122, 32'hb72074d4, 32'hdfa9bf2c
  };

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_word_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_word_t           out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  nonce_sha256_two_stage_hash_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  in_word_t    pending_words[$];
  out_word_t   pending_digests[$];
  logic [63:0] midstate_regs [NumMidRegs];
  block_t      block_words;
  int unsigned err_count;
  bit          in_took;
  bit          no_idle;
  bit          hold_armed;
  bit          hold_used;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned hold_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One compression of blk starting from st, without the feed-forward add
  function automatic state_t sha_rounds(input state_t st, input block_t blk);
    logic [31:0] sched [64];
    logic [31:0] t1;
    logic [31:0] t2;
    state_t      v;
    int          r;
    int          i;
    for (r = 0; r < 16; r++) sched[r] = blk[r];
    for (r = 16; r < 64; r++) begin
      sched[r] = sched[r-16] + sched[r-7]
               + (rotr(sched[r-15], 7) ^ rotr(sched[r-15], 18) ^ (sched[r-15] >> 3))
               + (rotr(sched[r-2], 17) ^ rotr(sched[r-2], 19) ^ (sched[r-2] >> 10));
    end
    v = st;
    for (r = 0; r < 64; r++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ShaK[r] + sched[r];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (i = 7; i > 0; i--) v[i] = v[i-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    return v;
  endfunction

  // Queue the eight digest words that a hash with this nonce must produce
  function automatic void predict_digests(input logic [31:0] nonce);
    state_t    mid;
    state_t    st;
    block_t    blk;
    out_word_t dw;
    int        i;
    for (i = 0; i < NumMidRegs; i++) begin
      mid[2*i]   = midstate_regs[i][63:32];
      mid[2*i+1] = midstate_regs[i][31:0];
    end
    blk = block_words;
    blk[NonceWord] = nonce;
    st = sha_rounds(mid, blk);
    blk = '0;
    for (i = 0; i < 8; i++) blk[i] = st[i] + mid[i];
    blk[8]  = BlkPad;
    blk[15] = BlkLen;
    st = sha_rounds(SecondIv, blk);
    for (i = 0; i < 8; i++) begin
      dw.digest_index = i[2:0];
      dw.digest_word  = st[i] + SecondIv[i];
      dw.last_word    = (i == 7);
      pending_digests.push_back(dw);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 150);
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return 32'h1 << $urandom_range(0, 31);
    return $urandom();
  endfunction

  function automatic bit drained();
    return pending_words.size() == 0 && !in_valid_i && pending_digests.size() == 0;
  endfunction

  task automatic push_load(input logic [3:0] idx, input logic [31:0] val);
    in_word_t w;
    w.req_type   = ReqLoad;
    w.word_index = idx;
    w.word_value = val;
    pending_words.push_back(w);
  endtask

  task automatic push_hash(input logic [31:0] nonce, input logic [3:0] junk_idx);
    in_word_t w;
    w.req_type   = ReqHash;
    w.word_index = junk_idx;
    w.word_value = nonce;
    pending_words.push_back(w);
  endtask

  // Wait until every word is taken and every digest has come out
  task automatic wait_drained();
    do @(posedge clk_i); while (!drained());
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Write all midstate registers, then every out-of-range index with junk
  task automatic set_midstate(input logic [63:0] m01, input logic [63:0] m23,
                              input logic [63:0] m45, input logic [63:0] m67);
    logic [63:0] vals [NumMidRegs];
    int          j;
    vals[RegMid01] = m01;
    vals[RegMid23] = m23;
    vals[RegMid45] = m45;
    vals[RegMid67] = m67;
    for (j = 0; j < 8; j++) begin
      @(negedge clk_i);
      cfg_valid_i = 1'b1;
      cfg_index_i = j[CfgIdxW-1:0];
      cfg_data_i  = (j < NumMidRegs) ? vals[j] : {$urandom(), $urandom()};
      do @(posedge clk_i); while (!cfg_ready_o);
      if (j < NumMidRegs) midstate_regs[j] = cfg_data_i;
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Sender: present queued words, hold while stalled, idle between words
  always @(negedge clk_i) begin
    if (in_valid_i && !in_took) begin
      // hold the stalled word
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid_i <= 1'b0;
    end else if (rst_ni && pending_words.size() > 0) begin
      in_data_i  <= pending_words.pop_front();
      in_valid_i <= 1'b1;
      send_gap = pick_gap();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver: random stalls, plus one long hold-off once armed
  always @(negedge clk_i) begin : recv_p
    int unsigned g;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_armed && !hold_used && out_valid_o) begin
      hold_used = 1'b1;
      hold_left = LongHold - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      g = pick_gap();
      if (g > 0) begin
        stall_left = g - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Track accepted words in the model and check every digest word
  always @(posedge clk_i) begin : mon_p
    out_word_t want;
    in_took = rst_ni && in_valid_i && !in_stall_o;
    if (in_took) begin
      if (in_data_i.req_type == ReqLoad) block_words[in_data_i.word_index] = in_data_i.word_value;
      else predict_digests(in_data_i.word_value);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_digests.size() == 0) begin
        flag_error($sformatf("unexpected digest word idx %0d data %08h",
                             out_data_o.digest_index, out_data_o.digest_word));
      end else begin
        want = pending_digests.pop_front();
        if (out_data_o.digest_index !== want.digest_index)
          flag_error($sformatf("digest_index got %0d want %0d",
                               out_data_o.digest_index, want.digest_index));
        if (out_data_o.digest_word !== want.digest_word)
          flag_error($sformatf("digest_word[%0d] got %08h want %08h", want.digest_index,
                               out_data_o.digest_word, want.digest_word));
        if (out_data_o.last_word !== want.last_word)
          flag_error($sformatf("last_word[%0d] got %0b want %0b", want.digest_index,
                               out_data_o.last_word, want.last_word));
      end
    end
  end

  // Stimulus: reset, directed words, then randomized phases
  initial begin : stim_p
    int          ph;
    int          n;
    int          k;
    int unsigned r;
    err_count   = 0;
    block_words = '0;
    for (n = 0; n < NumMidRegs; n++) midstate_regs[n] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: all-ones midstate, full block load with extreme words
    set_midstate('1, '1, '1, '1);
    push_load(4'd0, 32'h0000_0000);
    push_load(4'd1, 32'hffff_ffff);
    push_load(4'd2, 32'haaaa_aaaa);
    push_load(4'd3, 32'h5555_5555);
    for (n = 4; n < 16; n++) push_load(n[3:0], pick_value());
    push_hash(32'h0000_0000, 4'd15);
    push_hash(32'hffff_ffff, 4'd0);
    // stored word 3 changes, but the nonce still takes its place
    push_load(4'd3, 32'h1234_5678);
    push_hash(32'h8000_0000, 4'd3);
    wait_drained();

    // Directed: zero midstate
    set_midstate('0, '0, '0, '0);
    push_load(4'd15, 32'hffff_ffff);
    push_hash(32'h0000_0001, 4'd7);
    push_hash(32'h7fff_ffff, 4'd8);
    wait_drained();

    // Random phases: mostly load runs closed by a hash, some stray loads
    for (ph = 0; ph < 4; ph++) begin
      if (ph == 3) set_midstate(64'h8000_0000_0000_0001, {$urandom(), $urandom()},
                                64'h7fff_ffff_ffff_fffe, {$urandom(), $urandom()});
      else set_midstate({$urandom(), $urandom()}, {$urandom(), $urandom()},
                        {$urandom(), $urandom()}, {$urandom(), $urandom()});
      no_idle    = (ph == 2);
      hold_armed = 1'b1;
      n = 0;
      while (n < 38) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          k = $urandom_range(0, 3);
          repeat (k) push_load(4'($urandom_range(0, 15)), pick_value());
          push_hash(pick_value(), 4'($urandom_range(0, 15)));
          n += k + 1;
        end else if (r < 85) begin
          push_hash(pick_value(), 4'($urandom_range(0, 15)));
          n++;
        end else begin
          k = $urandom_range(1, 5);
          repeat (k) push_load(4'($urandom_range(0, 15)), pick_value());
          n += k;
        end
      end
      wait_drained();
    end

    repeat (TailWait) @(posedge clk_i);
    if (pending_digests.size() != 0)
      flag_error($sformatf("%0d digest words never arrived", pending_digests.size()));
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
